@@ design/rbst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

    // Three axes, two slab planes per axis: lane 2*a is the lower corner of
    // axis a, lane 2*a+1 the upper corner.
    localparam int AXES  = 3;
    localparam int LANES = 2 * AXES;

    // Per-item control that travels beside the division pipeline.
    typedef struct packed {
        logic [LANES-1:0] neg;     // quotient sign of each lane
        logic [AXES-1:0]  par;     // direction is exactly zero on this axis
        logic [AXES-1:0]  in_slab; // origin lies within [min, max] on this axis
    } side_t;

endpackage
`default_nettype wire

@@ design/rbst_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_divider
// Six-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbst_divider #(
    parameter int NW = 33,   // numerator magnitude width
    parameter int DW = 32,   // divisor magnitude width
    parameter int FB = 16    // fraction bits appended to the numerator
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [rbst_pkg::LANES-1:0][NW-1:0]   in_num,
    input  wire logic [rbst_pkg::LANES-1:0][DW-1:0]   in_den,
    input  wire rbst_pkg::side_t                      in_side,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [rbst_pkg::LANES-1:0][NW+FB-1:0]     out_quo,
    output rbst_pkg::side_t                           out_side
);

    localparam int QW = NW + FB;
    localparam int L  = rbst_pkg::LANES;

    logic                        v_reg    [QW:1];
    logic [L-1:0][DW-1:0]        rem_reg  [QW:1];
    logic [L-1:0][QW-1:0]        quo_reg  [QW:1];
    logic [L-1:0][QW-1:0]        dvd_reg  [QW:1];
    logic [L-1:0][DW-1:0]        den_reg  [QW:1];
    rbst_pkg::side_t             side_reg [QW:1];
    logic [QW:1]                 rdy;

    assign in_ready = rdy[1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                 cv;
        logic [L-1:0][DW-1:0] crem;
        logic [L-1:0][QW-1:0] cquo;
        logic [L-1:0][QW-1:0] cdvd;
        logic [L-1:0][DW-1:0] cden;
        rbst_pkg::side_t      cside;
        logic [L-1:0][DW-1:0] rem_next;
        logic [L-1:0][QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign cv    = in_valid;
            assign crem  = '0;
            assign cquo  = '0;
            assign cden  = in_den;
            assign cside = in_side;
            for (genvar l = 0; l < L; l++) begin : g_ld
                assign cdvd[l] = QW'(in_num[l]) << FB;
            end
        end else begin : g_mid
            assign cv    = v_reg[k];
            assign crem  = rem_reg[k];
            assign cquo  = quo_reg[k];
            assign cdvd  = dvd_reg[k];
            assign cden  = den_reg[k];
            assign cside = side_reg[k];
        end

        if (k == QW - 1) begin : g_last
            assign rdy[k+1] = !v_reg[k+1] || out_ready;
        end else begin : g_chain
            assign rdy[k+1] = !v_reg[k+1] || rdy[k+2];
        end

        // Shift in the next dividend bit, subtract the divisor when it fits.
        always_comb begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < L; l++) begin
                trial       = {crem[l], cdvd[l][QW-1]};
                ge          = trial >= {1'b0, cden[l]};
                rem_next[l] = ge ? DW'(trial - {1'b0, cden[l]}) : DW'(trial);
                quo_next[l] = {cquo[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (rdy[k+1]) begin
                v_reg[k+1] <= cv;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k+1] && cv) begin
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
                dvd_reg[k+1]  <= cdvd << 1;
                den_reg[k+1]  <= cden;
                side_reg[k+1] <= cside;
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule
`default_nettype wire

@@ design/rbst_resolve.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_resolve
// Saturate and sign the slab distances, order them, reduce to hit or miss.
// ----------------------------------------------------------------------------
module rbst_resolve #(
    parameter int CB = 32,   // coordinate width
    parameter int QW = 49    // raw quotient width
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [rbst_pkg::LANES-1:0][QW-1:0]  in_quo,
    input  wire rbst_pkg::side_t                     in_side,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     out_hit
);

    localparam int L = rbst_pkg::LANES;
    localparam int A = rbst_pkg::AXES;

    // stage a: signed, saturated distances
    logic                 a_v_reg;
    logic [L-1:0][CB-1:0] a_t_reg;
    logic [A-1:0]         a_par_reg, a_in_reg;
    logic [L-1:0][CB-1:0] a_t_next;
    logic                 a_rdy;

    // stage b: near / far per axis
    logic                 b_v_reg;
    logic [A-1:0][CB-1:0] b_lo_reg, b_hi_reg;
    logic [A-1:0]         b_par_reg, b_in_reg;
    logic [A-1:0][CB-1:0] b_lo_next, b_hi_next;
    logic                 b_rdy;

    // stage c: result register
    logic                 c_v_reg;
    logic                 c_hit_reg;
    logic                 c_hit_next;
    logic                 c_rdy;

    assign c_rdy    = !c_v_reg || out_ready;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_ready = a_rdy;

    always_comb begin
        logic [QW-1:0] lim;
        logic [QW-1:0] q;
        for (int l = 0; l < L; l++) begin
            lim = in_side.neg[l] ? (QW'(1) << (CB - 1)) : ((QW'(1) << (CB - 1)) - QW'(1));
            q   = (in_quo[l] > lim) ? lim : in_quo[l];
            a_t_next[l] = in_side.neg[l] ? CB'(-q[CB-1:0]) : q[CB-1:0];
        end
    end

    always_comb begin
        for (int a = 0; a < A; a++) begin
            if ($signed(a_t_reg[2*a]) > $signed(a_t_reg[2*a+1])) begin
                b_lo_next[a] = a_t_reg[2*a+1];
                b_hi_next[a] = a_t_reg[2*a];
            end else begin
                b_lo_next[a] = a_t_reg[2*a];
                b_hi_next[a] = a_t_reg[2*a+1];
            end
        end
    end

    // Entry only grows and exit only shrinks, so checking once at the end
    // matches checking after every axis.
    always_comb begin
        logic signed [CB-1:0] near;
        logic signed [CB-1:0] far;
        logic                 miss;
        near = {1'b1, {(CB-1){1'b0}}};
        far  = {1'b0, {(CB-1){1'b1}}};
        miss = 1'b0;
        for (int a = 0; a < A; a++) begin
            if (b_par_reg[a]) begin
                miss = miss | !b_in_reg[a];
            end else begin
                if ($signed(b_lo_reg[a]) > near) near = $signed(b_lo_reg[a]);
                if ($signed(b_hi_reg[a]) < far)  far  = $signed(b_hi_reg[a]);
            end
        end
        miss       = miss | (near > far) | far[CB-1];
        c_hit_next = !miss;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            if (a_rdy) a_v_reg <= in_valid;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && in_valid) begin
            a_t_reg   <= a_t_next;
            a_par_reg <= in_side.par;
            a_in_reg  <= in_side.in_slab;
        end
        if (b_rdy && a_v_reg) begin
            b_lo_reg  <= b_lo_next;
            b_hi_reg  <= b_hi_next;
            b_par_reg <= a_par_reg;
            b_in_reg  <= a_in_reg;
        end
        if (c_rdy && b_v_reg) begin
            c_hit_reg <= c_hit_next;
        end
    end

    assign out_valid = c_v_reg;
    assign out_hit   = c_hit_reg;

endmodule
`default_nettype wire

@@ design/ray_box_slab_test_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Ray against axis-aligned box slab test in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one ray/box pair per cycle unless stalled and returns one hit bit per
// pair, in order. Stages: one input stage, one divider stage per quotient bit
// of the six slab-distance divisions (COORD_BITS + 1 + FRAC_BITS of them),
// then saturate, order and reduce stages. Every stage holds its own valid bit
// and takes a new transfer whenever it is empty or its successor moves, so
// bubbles are squeezed out and the input keeps flowing while a result waits
// on m_axis_tready, until the pipeline fills. Distances are
// (corner - origin) << FRAC_BITS / direction, truncated toward zero and
// clamped to the signed COORD_BITS range; an axis with zero direction instead
// requires the origin to lie within [min, max], faces included.
module ray_box_slab_test_unit #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
    // box_min_z, box_max_x, box_max_y, box_max_z, each COORD_BITS, zero pad
    input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // hit in bit 0, zero pad
    output logic [7:0]                         m_axis_tdata
);

    localparam int CB = COORD_BITS;
    localparam int NW = CB + 1;
    localparam int DW = CB;
    localparam int QW = NW + FRAC_BITS;
    localparam int L  = rbst_pkg::LANES;
    localparam int A  = rbst_pkg::AXES;

    // input stage
    logic                 p_v_reg;
    logic [L-1:0][NW-1:0] p_num_reg, p_num_next;
    logic [L-1:0][DW-1:0] p_den_reg, p_den_next;
    rbst_pkg::side_t      p_side_reg, p_side_next;
    logic                 p_rdy;

    logic                 div_in_ready;
    logic                 div_out_valid;
    logic                 res_in_ready;
    logic [L-1:0][QW-1:0] div_quo;
    rbst_pkg::side_t      div_side;
    logic                 res_hit;

    assign p_rdy         = !p_v_reg || div_in_ready;
    assign s_axis_tready = p_rdy;

    // Split each axis into two plane differences and the divisor magnitude.
    always_comb begin
        logic signed [CB-1:0] o, d, lo, hi;
        logic signed [NW-1:0] dl, dh;
        for (int a = 0; a < A; a++) begin
            o  = $signed(s_axis_tdata[a*CB +: CB]);
            d  = $signed(s_axis_tdata[(3+a)*CB +: CB]);
            lo = $signed(s_axis_tdata[(6+a)*CB +: CB]);
            hi = $signed(s_axis_tdata[(9+a)*CB +: CB]);
            dl = $signed({lo[CB-1], lo}) - $signed({o[CB-1], o});
            dh = $signed({hi[CB-1], hi}) - $signed({o[CB-1], o});
            p_num_next[2*a]   = dl[NW-1] ? NW'(-dl) : NW'(dl);
            p_num_next[2*a+1] = dh[NW-1] ? NW'(-dh) : NW'(dh);
            p_den_next[2*a]   = d[CB-1] ? DW'(-d) : DW'(d);
            p_den_next[2*a+1] = d[CB-1] ? DW'(-d) : DW'(d);
            p_side_next.neg[2*a]   = dl[NW-1] ^ d[CB-1];
            p_side_next.neg[2*a+1] = dh[NW-1] ^ d[CB-1];
            p_side_next.par[a]     = (d == '0);
            p_side_next.in_slab[a] = !((o < lo) || (o > hi));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (p_rdy) begin
            p_v_reg <= s_axis_tvalid;
        end
    end

    // Hold payload unless a transfer lands in the input stage.
    always_ff @(posedge aclk) begin
        if (p_rdy && s_axis_tvalid) begin
            p_num_reg  <= p_num_next;
            p_den_reg  <= p_den_next;
            p_side_reg <= p_side_next;
        end
    end

    rbst_divider #(
        .NW (NW),
        .DW (DW),
        .FB (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_v_reg),
        .in_ready  (div_in_ready),
        .in_num    (p_num_reg),
        .in_den    (p_den_reg),
        .in_side   (p_side_reg),
        .out_valid (div_out_valid),
        .out_ready (res_in_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    rbst_resolve #(
        .CB (CB),
        .QW (QW)
    ) u_res (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_out_valid),
        .in_ready  (res_in_ready),
        .in_quo    (div_quo),
        .in_side   (div_side),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hit   (res_hit)
    );

    assign m_axis_tdata = {7'b0, res_hit};

    // Reset empties the pipeline: no result right after it.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input is only refused while the input stage holds an item.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> p_v_reg)
        else $error("input refused with empty input stage");

    // A blocked input stage keeps its item.
    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        p_v_reg && !div_in_ready |=> p_v_reg && $stable(p_num_reg)
            && $stable(p_den_reg) && $stable(p_side_reg))
        else $error("stalled input stage lost its item");

endmodule
`default_nettype wire
